>>> rtl/cpsm_pkg.sv
// Shared types and constants for the capture period speed meter.
// No dependencies; every other file imports this package.
package cpsm_pkg;

    // Field widths
    localparam int CLK_W   = 26;
    localparam int DIST_W  = 16;
    localparam int TICK_W  = 32;
    localparam int SPEED_W = 16;
    localparam int MAG_W   = SPEED_W - 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

    localparam logic [CLK_W-1:0]  CLOCK_FREQ_RESET = 26'd48000000;
    localparam logic [DIST_W-1:0] DISTANCE_RESET   = 16'd1075;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET    = 32'd1075;

    // Request codes
    localparam logic REQ_CAPTURE = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // Arithmetic
    localparam int OVERSAMPLE_SHIFT = 6;       // x64
    localparam int DIV_W  = TICK_W;
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int PROD_W = DIV_W + DIST_W;
    localparam int MCNT_W = $clog2(DIST_W + 1);
    localparam logic [DIV_W-1:0]  SCALE_DIV = 32'd64000;
    localparam logic [MAG_W-1:0]  SPEED_MAX = 15'd32767;
    localparam logic [PROD_W-1:0] SAT_LIMIT = 48'd2097152000;  // 32768 * 64000

    localparam int SLOTS_DEFAULT = 2;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   rem;
        logic [DIV_W-1:0]   num;
        logic [DIV_W-1:0]   den;
        logic [STEP_W-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_sts_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  mcand;
        logic [DIST_W-1:0] mplier;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_sts_t;

endpackage

>>> rtl/cpsm_if.sv
// Valid/ready channel interfaces for event requests and speed results.
// Depends on cpsm_pkg.
interface cpsm_event_if import cpsm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TICK_W-1:0] capture_count;
    logic              reverse_dir;
    logic [TICK_W-1:0] systick_now;

    modport source (output valid, req_type, capture_count, reverse_dir, systick_now,
                    input ready);
    modport sink   (input valid, req_type, capture_count, reverse_dir, systick_now,
                    output ready);
endinterface

interface cpsm_speed_if import cpsm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] speed_mm_s;
    logic                      slot_written;
    logic                      from_timeout;

    modport source (output valid, speed_mm_s, slot_written, from_timeout, input ready);
    modport sink   (input valid, speed_mm_s, slot_written, from_timeout, output ready);
endinterface

>>> rtl/cpsm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on cpsm_pkg (div_req_t, div_sts_t).
module cpsm_div import cpsm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_sts_t sts
);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  sh_reg;
    logic [DIV_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    trial;
    logic [DIV_W+1:0]  diff;
    logic              fits;

    // shift next numerator bit into the partial remainder, try a subtract
    assign trial = {rem_reg, sh_reg[DIV_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[DIV_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            sh_reg   <= '0;
            den_reg  <= '0;
        end
        else if (req.start)
        begin
            rem_reg  <= req.rem;
            sh_reg   <= req.num;
            den_reg  <= req.den;
            cnt_reg  <= req.steps;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            sh_reg  <= {sh_reg[DIV_W-2:0], fits};
            cnt_reg <= cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.done = done_reg;
    assign sts.quot = sh_reg;

endmodule

>>> rtl/cpsm_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on cpsm_pkg (mul_req_t, mul_sts_t).
module cpsm_mul import cpsm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_sts_t sts
);

    logic [DIV_W-1:0]  acc_reg;
    logic [DIST_W-1:0] low_reg;
    logic [DIV_W-1:0]  mcand_reg;
    logic [MCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_W:0]    sum;

    assign sum = {1'b0, acc_reg} + (low_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            low_reg   <= '0;
            mcand_reg <= '0;
        end
        else if (req.start)
        begin
            acc_reg   <= '0;
            low_reg   <= req.mplier;
            mcand_reg <= req.mcand;
            cnt_reg   <= MCNT_W'(DIST_W);
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum[DIV_W:1];
            low_reg <= {sum[0], low_reg[DIST_W-1:1]};
            cnt_reg <= cnt_reg - MCNT_W'(1);
            if (cnt_reg == MCNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign sts.done = done_reg;
    assign sts.prod = {acc_reg, low_reg};

endmodule

>>> rtl/capture_period_speed_meter_unit.sv
// Top level of the capture period speed meter: sequencer, state, config, output register.
// Depends on cpsm_pkg, cpsm_if, cpsm_div and cpsm_mul.
//
//  channel    dir  type           transfer when        payload
//  event_ch   in   cpsm_event_if  valid & ready        req_type, capture_count,
//                                                      reverse_dir, systick_now
//  speed_ch   out  cpsm_speed_if  valid & ready        speed_mm_s, slot_written,
//                                                      from_timeout
//  cfg_*      in   plain write    cfg_we               cfg_index, cfg_data
//
// One request is worked at a time. A capture with a nonzero period goes from transfer
// to result through the serial passes: the serial divider runs 32 steps for
// 64*clock/period and 15 steps for the /64000 scale, the serial multiplier 16 steps.
// A zero period or an overflowing product skips the later passes; a timeout check
// goes through ST_TCMP and gives a result only once the timeout has expired. Reset
// is asynchronous and leaves the unit ready at once.
// A stalled result is held in the output register; the next request is taken
// meanwhile and waits in its final step until the register frees up.
module capture_period_speed_meter_unit import cpsm_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    cpsm_event_if.sink            event_ch,
    cpsm_speed_if.source          speed_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_TCMP,
        ST_DSTART,
        ST_DIV1,
        ST_MUL,
        ST_SAT,
        ST_DIV2,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // configuration
    logic [CLK_W-1:0]  clock_freq_reg;
    logic [DIST_W-1:0] distance_reg;
    logic [TICK_W-1:0] timeout_reg;

    // request held for the duration of the computation
    logic              req_type_reg;
    logic [TICK_W-1:0] capture_reg;
    logic              reverse_reg;
    logic [TICK_W-1:0] now_reg;

    // running state of the meter
    logic [TICK_W-1:0] last_capture_reg;
    logic [TICK_W-1:0] last_update_reg;
    logic [SLOT_W-1:0] slot_reg;

    // working values
    logic [TICK_W-1:0] diff_reg;    // period or elapsed ticks
    logic [MAG_W-1:0]  mag_reg;

    // output register
    logic               out_valid_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic               out_slot_reg;
    logic               out_tmo_reg;

    div_req_t div_req;
    div_sts_t div_sts;
    mul_req_t mul_req;
    mul_sts_t mul_sts;

    logic               out_free;
    logic               saturate;
    logic [SPEED_W-1:0] speed_val;
    logic [SLOT_W-1:0]  slot_next;

    assign out_free = ~out_valid_reg | speed_ch.ready;
    assign saturate = (mul_sts.prod >= SAT_LIMIT);
    assign slot_next = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + SLOT_W'(1);

    // sign is applied after saturation; timeout results are always zero
    assign speed_val = (req_type_reg == REQ_CAPTURE && reverse_reg)
                       ? SPEED_W'(~{1'b0, mag_reg} + SPEED_W'(1))
                       : {1'b0, mag_reg};

    // divider is shared: first pass 64*clock / period, second pass product / 64000.
    // Second pass starts with the upper product bits already in the remainder,
    // which is below the divisor whenever the product did not saturate.
    always_comb
    begin
        div_req       = '0;
        div_req.start = 1'b0;
        case (state_reg)
            ST_DSTART:
            begin
                div_req.start = (diff_reg != '0);
                div_req.rem   = '0;
                div_req.num   = {clock_freq_reg, OVERSAMPLE_SHIFT'(0)};
                div_req.den   = diff_reg;
                div_req.steps = STEP_W'(DIV_W);
            end
            ST_SAT:
            begin
                div_req.start = ~saturate;
                div_req.rem   = DIV_W'(mul_sts.prod >> MAG_W);
                div_req.num   = {mul_sts.prod[MAG_W-1:0], (DIV_W - MAG_W)'(0)};
                div_req.den   = SCALE_DIV;
                div_req.steps = STEP_W'(MAG_W);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign mul_req.start  = (state_reg == ST_DIV1) && div_sts.done;
    assign mul_req.mcand  = div_sts.quot;
    assign mul_req.mplier = distance_reg;

    cpsm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .sts   (div_sts)
    );

    cpsm_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .sts   (mul_sts)
    );

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_freq_reg <= CLOCK_FREQ_RESET;
            distance_reg   <= DISTANCE_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLOCK_FREQ: clock_freq_reg <= cfg_data[CLK_W-1:0];
                CFG_DISTANCE:   distance_reg   <= cfg_data[DIST_W-1:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer, meter state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            req_type_reg     <= REQ_CAPTURE;
            capture_reg      <= '0;
            reverse_reg      <= 1'b0;
            now_reg          <= '0;
            last_capture_reg <= '0;
            last_update_reg  <= '0;
            slot_reg         <= '0;
            diff_reg         <= '0;
            mag_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_speed_reg    <= '0;
            out_slot_reg     <= 1'b0;
            out_tmo_reg      <= 1'b0;
        end
        else
        begin
            // in ST_EMIT the output register is reloaded below instead
            if (out_valid_reg && speed_ch.ready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (event_ch.valid)
                    begin
                        req_type_reg <= event_ch.req_type;
                        capture_reg  <= event_ch.capture_count;
                        reverse_reg  <= event_ch.reverse_dir;
                        now_reg      <= event_ch.systick_now;
                        state_reg    <= ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    if (req_type_reg == REQ_TIMEOUT)
                    begin
                        diff_reg  <= now_reg - last_update_reg;
                        state_reg <= ST_TCMP;
                    end
                    else
                    begin
                        // wraps modulo 2^32
                        diff_reg         <= capture_reg - last_capture_reg;
                        last_capture_reg <= capture_reg;
                        state_reg        <= ST_DSTART;
                    end
                end
                ST_TCMP:
                begin
                    mag_reg <= '0;
                    // no expiry: nothing written, nothing emitted
                    state_reg <= (diff_reg > timeout_reg) ? ST_EMIT : ST_IDLE;
                end
                ST_DSTART:
                begin
                    if (diff_reg == '0)
                    begin
                        mag_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV1;
                    end
                end
                ST_DIV1:
                begin
                    if (div_sts.done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (mul_sts.done)
                    begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT:
                begin
                    if (saturate)
                    begin
                        mag_reg   <= SPEED_MAX;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2:
                begin
                    if (div_sts.done)
                    begin
                        mag_reg   <= div_sts.quot[MAG_W-1:0];
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_speed_reg   <= speed_val;
                        out_slot_reg    <= slot_reg[0];
                        out_tmo_reg     <= (req_type_reg == REQ_TIMEOUT);
                        slot_reg        <= slot_next;
                        last_update_reg <= now_reg;
                        state_reg       <= ST_IDLE;
                    end
                    else if (out_valid_reg && speed_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign event_ch.ready      = (state_reg == ST_IDLE);
    assign speed_ch.valid      = out_valid_reg;
    assign speed_ch.speed_mm_s = out_speed_reg;
    assign speed_ch.slot_written = out_slot_reg;
    assign speed_ch.from_timeout = out_tmo_reg;

endmodule

>>> rtl/cpsm_checker.sv
// Port-level checks for the capture period speed meter, bound to the top level.
// Depends on cpsm_pkg and capture_period_speed_meter_unit.
module cpsm_checker import cpsm_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               ev_valid,
    input logic               ev_ready,
    input logic               sp_valid,
    input logic               sp_ready,
    input logic [SPEED_W-1:0] sp_speed,
    input logic               sp_slot,
    input logic               sp_tmo
);

    // a held result keeps its payload until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sp_valid && !sp_ready |=> sp_valid && $stable(sp_speed)
                                 && $stable(sp_slot) && $stable(sp_tmo))
        else $error("speed result changed while stalled");

    // saturation is symmetric, so the most negative code never appears
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        sp_valid |-> sp_speed != {1'b1, {(SPEED_W-1){1'b0}}})
        else $error("speed hit the most negative code");

    a_tmo_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sp_valid && sp_tmo |-> sp_speed == '0)
        else $error("timeout result is not zero");

    // one request at a time: ready drops right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready |=> !ev_ready)
        else $error("request accepted while another is in work");

endmodule

bind capture_period_speed_meter_unit cpsm_checker u_cpsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (event_ch.valid),
    .ev_ready (event_ch.ready),
    .sp_valid (speed_ch.valid),
    .sp_ready (speed_ch.ready),
    .sp_speed (speed_ch.speed_mm_s),
    .sp_slot  (speed_ch.slot_written),
    .sp_tmo   (speed_ch.from_timeout)
);
